@@ rtl/core/hba_pkg.sv @@
// ----------------------------------------------------------------------------
// hba_pkg: shared definitions of the hue band HSB adjuster
// Widths, band edges, reciprocal constants, the item type that travels
// between the delta stages and the tone stages, and small helper functions.
// ----------------------------------------------------------------------------
package hba_pkg;

   localparam int NUM_BANDS  = 7;
   localparam int NUM_COLORS = NUM_BANDS - 1;
   localparam int NUM_COMPS  = 3;
   localparam int SHIFT_W    = 25;
   localparam int HUE_W      = 9;
   localparam int PIX_W      = 16;
   localparam int IDX_W      = 3;

   // Component codes of a packed shift register.
   localparam int COMP_HUE = 0;
   localparam int COMP_SAT = 1;
   localparam int COMP_BRI = 2;

   localparam logic [9:0] RAMP_DEG       = 10'd30;
   localparam logic [9:0] HUE_FULL_TURN  = 10'd360;

   // Ramp start, flat start, flat end, ramp end of each colour band.
   localparam logic [8:0] BAND_EDGE [NUM_COLORS][4] = '{
      '{9'd315, 9'd345, 9'd15,  9'd45 },
      '{9'd15,  9'd45,  9'd75,  9'd105},
      '{9'd75,  9'd105, 9'd135, 9'd165},
      '{9'd135, 9'd165, 9'd195, 9'd225},
      '{9'd195, 9'd225, 9'd255, 9'd285},
      '{9'd255, 9'd285, 9'd315, 9'd345}
   };

   // floor(x / 30) = (x * 8739) >> 18, exact for x below 10082.
   localparam logic [13:0] RECIP_30 = 14'd8739;
   // floor(x / 360) = (x * 2913) >> 20, exact for x below 10082.
   localparam logic [11:0] RECIP_360 = 12'd2913;
   // floor(x / 100) = (x * 10737419) >> 30, exact for x below 14128182.
   localparam logic [23:0] RECIP_100 = 24'd10737419;

   localparam logic [12:0] HUE_BIAS   = 13'd1800;
   localparam logic [8:0]  HUE_MOD    = 9'd360;
   localparam logic [15:0] Q16_ONE    = 16'hFFFF;
   localparam logic [7:0]  PCT_FULL   = 8'd100;

   typedef logic [NUM_BANDS-1:0][SHIFT_W-1:0] shift_array_type;

   typedef struct packed {
      logic               valid;
      logic [HUE_W-1:0]   hue;
      logic [PIX_W-1:0]   sat;
      logic [PIX_W-1:0]   bri;
      logic signed [11:0] dh;
      logic signed [7:0]  ds;
      logic signed [7:0]  db;
   } delta_type;

   // One signed component of a packed shift register, widened to 9 bits.
   function automatic logic signed [8:0] shift_field(input logic [SHIFT_W-1:0] value,
                                                     input int comp);
      logic signed [8:0] f;
      case (comp)
         COMP_HUE: f = value[8:0];
         COMP_SAT: f = {value[16], value[16:9]};
         COMP_BRI: f = {value[24], value[24:17]};
         default:  f = '0;
      endcase
      return f;
   endfunction

   // Weight 0..30 of a colour band at the given hue.
   function automatic logic [4:0] band_weight(input logic [HUE_W-1:0] hue, input int band);
      logic [9:0] h;
      logic [9:0] ll;
      logic [9:0] l;
      logic [9:0] r;
      logic [9:0] rr;
      logic [9:0] w;
      h  = {1'b0, hue};
      ll = {1'b0, BAND_EDGE[band][0]};
      l  = {1'b0, BAND_EDGE[band][1]};
      r  = {1'b0, BAND_EDGE[band][2]};
      rr = {1'b0, BAND_EDGE[band][3]};
      w  = '0;
      if (l < r) begin
         if (h >= l && h <= r) begin
            w = RAMP_DEG;
         end else if (h >= ll && h <= l) begin
            w = h - ll;
         end else if (h >= r && h <= rr) begin
            w = rr - h;
         end
      end else begin
         // The band wraps through zero degrees.
         if ((h >= l && h <= HUE_FULL_TURN) || h <= r) begin
            w = RAMP_DEG;
         end else if (h >= ll && h <= l) begin
            w = h - ll;
         end else if (h >= r && h <= rr) begin
            w = rr - h;
         end
      end
      return w[4:0];
   endfunction

   // Clip a summed delta to -100..100.
   function automatic logic signed [7:0] clip_pct(input logic signed [11:0] v);
      logic signed [7:0] c;
      if (v > 12'sd100) begin
         c = 8'sd100;
      end else if (v < -12'sd100) begin
         c = -8'sd100;
      end else begin
         c = v[7:0];
      end
      return c;
   endfunction

endpackage

@@ rtl/core/hue_band_hsb_adjust.sv @@
// ----------------------------------------------------------------------------
// hue_band_hsb_adjust: banded hue, saturation and brightness adjustment
// Adjusts one HSB pixel per clock from a master shift and six colour bands.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel item enters on the req_ ports at a rising clock edge at which
//   start is high and busy is low. The block never holds items off, so busy
//   stays low and an item may be offered in every cycle.
//   The result item appears on the rsp_ ports once its item has passed the
//   pipeline, marked by rsp_valid for exactly one cycle. Items leave in
//   the order they entered, one per cycle at full rate.
//   The pipeline has eight stages: four for band weights,
//   products, division by the ramp width and the band sum, and four for the
//   saturation and brightness products and their divisions by 100, with the
//   hue wrap running beside the latter.
//   The receiver cannot stall: rsp_valid marks a one-cycle strobe that must
//   be taken when it is shown.
//   The seven band shift registers are written over the csr_ channel, which
//   is always ready; writes take effect at the next edge and should be made
//   only while no item is in flight. Indexes beyond the last band are ignored.
//   Reset, synchronous and active high, clears all shift registers to zero
//   and drops every item still in the pipeline.
// ----------------------------------------------------------------------------
module hue_band_hsb_adjust (
   input  logic                         clock,
   input  logic                         reset,
   // Pixel input channel.
   input  logic                         start,
   output logic                         busy,
   input  logic [hba_pkg::HUE_W-1:0]    req_in_hue,
   input  logic [hba_pkg::PIX_W-1:0]    req_in_saturation,
   input  logic [hba_pkg::PIX_W-1:0]    req_in_brightness,
   // Result channel.
   output logic                         rsp_valid,
   output logic [hba_pkg::HUE_W-1:0]    rsp_out_hue,
   output logic [hba_pkg::PIX_W-1:0]    rsp_out_saturation,
   output logic [hba_pkg::PIX_W-1:0]    rsp_out_brightness,
   // Configuration channel.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hba_pkg::IDX_W-1:0]    csr_index,
   input  logic [hba_pkg::SHIFT_W-1:0]  csr_wdata
);
   import hba_pkg::*;

   shift_array_type shift;
   delta_type       delta;
   logic            accept;

   // The pipeline advances every cycle, so it can always take an item.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   hba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .shift     (shift)
   );

   // Stages one to four: per-band weights and summed deltas, the tone deltas clipped.
   hba_band_sum u_band_sum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_hue   (req_in_hue),
      .in_sat   (req_in_saturation),
      .in_bri   (req_in_brightness),
      .shift    (shift),
      .delta    (delta)
   );

   // Stages five to eight: hue wrap, kept in step with the tone stages.
   hba_hue_wrap u_hue_wrap (
      .clock   (clock),
      .delta   (delta),
      .out_hue (rsp_out_hue)
   );

   // Stages five to eight: saturation then brightness, each with its cross
   // effect on the other component.
   hba_tone u_tone (
      .clock     (clock),
      .reset     (reset),
      .delta     (delta),
      .out_valid (rsp_valid),
      .out_sat   (rsp_out_saturation),
      .out_bri   (rsp_out_brightness)
   );

endmodule

@@ rtl/core/hba_csr.sv @@
// ----------------------------------------------------------------------------
// hba_csr: shift register file
// Seven packed band shift registers, written one at a time over the
// configuration channel; writes beyond the last register are dropped.
// ----------------------------------------------------------------------------
module hba_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hba_pkg::IDX_W-1:0]    csr_index,
   input  logic [hba_pkg::SHIFT_W-1:0]  csr_wdata,
   output hba_pkg::shift_array_type     shift
);
   import hba_pkg::*;

   shift_array_type shift_ff;
   shift_array_type shift_in;

   always_comb begin
      shift_in = shift_ff;
      if (csr_valid && csr_index < IDX_W'(NUM_BANDS)) begin
         shift_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else begin
         shift_ff <= shift_in;
      end
   end

   assign csr_ready = 1'b1;
   assign shift     = shift_ff;

endmodule

@@ rtl/core/hba_band_sum.sv @@
// ----------------------------------------------------------------------------
// hba_band_sum: band weighting and delta summation
// Four stages: band weights, weighted products, division by the ramp
// width, and the sum over all bands with clipping of the tone deltas.
// ----------------------------------------------------------------------------
module hba_band_sum (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [hba_pkg::HUE_W-1:0]  in_hue,
   input  logic [hba_pkg::PIX_W-1:0]  in_sat,
   input  logic [hba_pkg::PIX_W-1:0]  in_bri,
   input  hba_pkg::shift_array_type   shift,
   output hba_pkg::delta_type         delta
);
   import hba_pkg::*;

   // Stage 1: weights.
   logic                                 v1_ff;
   logic [HUE_W-1:0]                     h1_ff;
   logic [PIX_W-1:0]                     s1_ff;
   logic [PIX_W-1:0]                     b1_ff;
   logic [NUM_COLORS-1:0][4:0]           d1_ff;
   logic [NUM_COLORS-1:0][4:0]           d1_in;

   // Stage 2: shift times weight.
   logic                                 v2_ff;
   logic [HUE_W-1:0]                     h2_ff;
   logic [PIX_W-1:0]                     s2_ff;
   logic [PIX_W-1:0]                     b2_ff;
   logic [NUM_COLORS-1:0][NUM_COMPS-1:0][13:0] p2_ff;
   logic [NUM_COLORS-1:0][NUM_COMPS-1:0][13:0] p2_in;
   logic signed [14:0]                   prod [NUM_COLORS][NUM_COMPS];

   // Stage 3: weighted shifts.
   logic                                 v3_ff;
   logic [HUE_W-1:0]                     h3_ff;
   logic [PIX_W-1:0]                     s3_ff;
   logic [PIX_W-1:0]                     b3_ff;
   logic [NUM_COLORS-1:0][NUM_COMPS-1:0][9:0] w3_ff;
   logic [NUM_COLORS-1:0][NUM_COMPS-1:0][9:0] w3_in;
   logic [13:0]                          mag  [NUM_COLORS][NUM_COMPS];
   logic [26:0]                          quo  [NUM_COLORS][NUM_COMPS];

   // Stage 4: sums.
   delta_type                            delta_ff;
   delta_type                            delta_in;
   logic signed [11:0]                   acc [NUM_COMPS];
   logic signed [8:0]                    mfield [NUM_COMPS];

   always_comb begin
      for (int b = 0; b < NUM_COLORS; b++) begin
         d1_in[b] = band_weight(in_hue, b);
      end
   end

   always_comb begin
      for (int b = 0; b < NUM_COLORS; b++) begin
         for (int c = 0; c < NUM_COMPS; c++) begin
            prod[b][c]  = shift_field(shift[b + 1], c) * $signed({1'b0, d1_ff[b]});
            p2_in[b][c] = prod[b][c][13:0];
         end
      end
   end

   // Truncating division by 30 on the magnitude keeps rounding toward zero.
   always_comb begin
      for (int b = 0; b < NUM_COLORS; b++) begin
         for (int c = 0; c < NUM_COMPS; c++) begin
            mag[b][c] = p2_ff[b][c][13] ? (14'd0 - p2_ff[b][c]) : p2_ff[b][c];
            quo[b][c] = mag[b][c][12:0] * RECIP_30;
            w3_in[b][c] = p2_ff[b][c][13] ? (10'd0 - {1'b0, quo[b][c][26:18]})
                                          : {1'b0, quo[b][c][26:18]};
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_COMPS; c++) begin
         mfield[c] = shift_field(shift[0], c);
         acc[c]    = {{3{mfield[c][8]}}, mfield[c]};
         for (int b = 0; b < NUM_COLORS; b++) begin
            acc[c] = acc[c] + {{2{w3_ff[b][c][9]}}, w3_ff[b][c]};
         end
      end
      delta_in.valid = v3_ff;
      delta_in.hue   = h3_ff;
      delta_in.sat   = s3_ff;
      delta_in.bri   = b3_ff;
      delta_in.dh    = acc[COMP_HUE];
      delta_in.ds    = clip_pct(acc[COMP_SAT]);
      delta_in.db    = clip_pct(acc[COMP_BRI]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         delta_ff.valid <= 1'b0;
      end else begin
         v1_ff          <= in_valid;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         delta_ff.valid <= delta_in.valid;
      end
      h1_ff <= in_hue;
      s1_ff <= in_sat;
      b1_ff <= in_bri;
      d1_ff <= d1_in;
      h2_ff <= h1_ff;
      s2_ff <= s1_ff;
      b2_ff <= b1_ff;
      p2_ff <= p2_in;
      h3_ff <= h2_ff;
      s3_ff <= s2_ff;
      b3_ff <= b2_ff;
      w3_ff <= w3_in;
      delta_ff.hue <= delta_in.hue;
      delta_ff.sat <= delta_in.sat;
      delta_ff.bri <= delta_in.bri;
      delta_ff.dh  <= delta_in.dh;
      delta_ff.ds  <= delta_in.ds;
      delta_ff.db  <= delta_in.db;
   end

   assign delta = delta_ff;

endmodule

@@ rtl/core/hba_hue_wrap.sv @@
// ----------------------------------------------------------------------------
// hba_hue_wrap: hue addition and wrap into 0..359
// A reciprocal quotient, a remainder step, then two stages that keep the
// hue in line with the tone stages.
// ----------------------------------------------------------------------------
module hba_hue_wrap (
   input  logic                       clock,
   input  hba_pkg::delta_type         delta,
   output logic [hba_pkg::HUE_W-1:0]  out_hue
);
   import hba_pkg::*;

   logic [12:0]      x5_ff;
   logic [12:0]      x5_in;
   logic [3:0]       q5_ff;
   logic [24:0]      q5_prod;
   logic [HUE_W-1:0] h6_ff;
   logic [12:0]      r6;
   logic [HUE_W-1:0] h7_ff;
   logic [HUE_W-1:0] h8_ff;

   // The bias is a multiple of 360, so the sum is never negative.
   always_comb begin
      x5_in   = {4'd0, delta.hue} + {delta.dh[11], delta.dh} + HUE_BIAS;
      q5_prod = x5_in * RECIP_360;
      r6      = x5_ff - (13'(q5_ff) * 13'(HUE_MOD));
   end

   always_ff @(posedge clock) begin
      x5_ff <= x5_in;
      q5_ff <= q5_prod[23:20];
      h6_ff <= r6[8:0];
      h7_ff <= h6_ff;
      h8_ff <= h7_ff;
   end

   assign out_hue = h8_ff;

endmodule

@@ rtl/core/hba_tone.sv @@
// ----------------------------------------------------------------------------
// hba_tone: saturation and brightness adjustment
// Four stages: saturation delta product and its division by 100, then the
// brightness delta product and its division by 100.
// ----------------------------------------------------------------------------
module hba_tone (
   input  logic                       clock,
   input  logic                       reset,
   input  hba_pkg::delta_type         delta,
   output logic                       out_valid,
   output logic [hba_pkg::PIX_W-1:0]  out_sat,
   output logic [hba_pkg::PIX_W-1:0]  out_bri
);
   import hba_pkg::*;

   function automatic logic [15:0] div100(input logic [22:0] x);
      logic [46:0] p;
      p = x * RECIP_100;
      return p[45:30];
   endfunction

   // Stage 5.
   logic                    v5_ff;
   logic [PIX_W-1:0]        s5_ff;
   logic [PIX_W-1:0]        b5_ff;
   logic                    neg5_ff;
   logic signed [7:0]       db5_ff;
   logic [22:0]             ps5_ff;
   logic [22:0]             pb5_ff;
   logic [22:0]             ps5_in;
   logic [22:0]             pb5_in;
   logic [7:0]              fac5;

   // Stage 6.
   logic                    v6_ff;
   logic [PIX_W-1:0]        s6_ff;
   logic [PIX_W-1:0]        b6_ff;
   logic signed [7:0]       db6_ff;
   logic [PIX_W-1:0]        s6_in;
   logic [PIX_W-1:0]        b6_in;
   logic [PIX_W-1:0]        qs6;

   // Stage 7.
   logic                    v7_ff;
   logic [PIX_W-1:0]        s7_ff;
   logic [PIX_W-1:0]        b7_ff;
   logic                    neg7_ff;
   logic [22:0]             ps7_ff;
   logic [22:0]             pb7_ff;
   logic [22:0]             ps7_in;
   logic [22:0]             pb7_in;
   logic [7:0]              fac7;

   // Stage 8.
   logic                    v8_ff;
   logic [PIX_W-1:0]        s8_ff;
   logic [PIX_W-1:0]        b8_ff;
   logic [PIX_W-1:0]        s8_in;
   logic [PIX_W-1:0]        b8_in;

   // A negative delta scales its own component by (100 + d); a positive one
   // blends toward full scale.
   always_comb begin
      fac5 = delta.ds[7] ? (PCT_FULL + delta.ds) : delta.ds;
      if (delta.ds[7]) begin
         ps5_in = delta.sat * fac5[6:0];
         pb5_in = '0;
      end else begin
         ps5_in = (Q16_ONE - delta.sat) * fac5[6:0];
         pb5_in = (Q16_ONE - delta.bri) * fac5[6:0];
      end
   end

   always_comb begin
      qs6   = div100(ps5_ff);
      s6_in = neg5_ff ? qs6 : (s5_ff + qs6);
      b6_in = b5_ff + div100(pb5_ff);
   end

   always_comb begin
      fac7 = db6_ff[7] ? (PCT_FULL + db6_ff) : db6_ff;
      if (db6_ff[7]) begin
         pb7_in = b6_ff * fac7[6:0];
         ps7_in = '0;
      end else begin
         pb7_in = (Q16_ONE - b6_ff) * fac7[6:0];
         ps7_in = s6_ff * fac7[6:0];
      end
   end

   always_comb begin
      b8_in = neg7_ff ? div100(pb7_ff) : (b7_ff + div100(pb7_ff));
      s8_in = s7_ff - div100(ps7_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v5_ff <= delta.valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
      s5_ff   <= delta.sat;
      b5_ff   <= delta.bri;
      neg5_ff <= delta.ds[7];
      db5_ff  <= delta.db;
      ps5_ff  <= ps5_in;
      pb5_ff  <= pb5_in;
      s6_ff   <= s6_in;
      b6_ff   <= b6_in;
      db6_ff  <= db5_ff;
      s7_ff   <= s6_ff;
      b7_ff   <= b6_ff;
      neg7_ff <= db6_ff[7];
      ps7_ff  <= ps7_in;
      pb7_ff  <= pb7_in;
      s8_ff   <= s8_in;
      b8_ff   <= b8_in;
   end

   assign out_valid = v8_ff;
   assign out_sat   = s8_ff;
   assign out_bri   = b8_ff;

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking regression of hue_band_hsb_adjust
// Feeds HSB pixel items through the adjuster under a series of band shift
// settings and checks every result item against a behavioral predictor.
// Settings include reset values, field extremes and random packings.
// ----------------------------------------------------------------------------
module testbench;

   // Run shape. Random phases hold most of the traffic; the first eight
   // phases step through every kind of shift setting once, which puts the
   // field extremes in early.
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 1000;
   localparam int MAX_REPORTS   = 10;

   // Arithmetic constants of the adjustment.
   localparam int HUE_TURN = 360;
   localparam int PCT_FULL = 100;
   localparam int UNITY    = 65535;

   // Ramp start, flat start, flat end and ramp end of each colour band, in
   // degrees. The red band wraps through zero.
   localparam int BAND_DEG [6][4] = '{
      '{315, 345,  15,  45},
      '{ 15,  45,  75, 105},
      '{ 75, 105, 135, 165},
      '{135, 165, 195, 225},
      '{195, 225, 255, 285},
      '{255, 285, 315, 345}
   };

   // Register indexes of the shift channel. The last index has no register
   // behind it, and a write to it must change nothing.
   typedef enum logic [hba_pkg::IDX_W-1:0] {
      SHIFT_MASTER, SHIFT_RED, SHIFT_YELLOW, SHIFT_GREEN,
      SHIFT_CYAN, SHIFT_BLUE, SHIFT_MAGENTA, SHIFT_NONE
   } shift_reg_type;

   // Kinds of band shift settings that a phase can run under.
   typedef enum int {
      SET_ZERO, SET_MAX, SET_MIN, SET_ALL_ONES,
      SET_MEANT, SET_RAW, SET_MASTER_ONLY, SET_ONE_BAND
   } setting_type;

   // One pixel, used both for the offered item and for the adjusted result.
   typedef struct {
      logic [hba_pkg::HUE_W-1:0] hue;
      logic [hba_pkg::PIX_W-1:0] sat;
      logic [hba_pkg::PIX_W-1:0] bri;
   } hsb_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        start              = 1'b0;
   logic                        busy;
   logic [hba_pkg::HUE_W-1:0]   req_in_hue         = '0;
   logic [hba_pkg::PIX_W-1:0]   req_in_saturation  = '0;
   logic [hba_pkg::PIX_W-1:0]   req_in_brightness  = '0;
   logic                        rsp_valid;
   logic [hba_pkg::HUE_W-1:0]   rsp_out_hue;
   logic [hba_pkg::PIX_W-1:0]   rsp_out_saturation;
   logic [hba_pkg::PIX_W-1:0]   rsp_out_brightness;
   logic                        csr_valid          = 1'b0;
   logic                        csr_ready;
   logic [hba_pkg::IDX_W-1:0]   csr_index          = '0;
   logic [hba_pkg::SHIFT_W-1:0] csr_wdata          = '0;

   // Band shifts as the block should hold them, and the set that the next
   // configuration pass will write.
   logic [hba_pkg::SHIFT_W-1:0] band_shift [hba_pkg::NUM_BANDS];
   logic [hba_pkg::SHIFT_W-1:0] shift_plan [hba_pkg::NUM_BANDS];

   hsb_pixel_type pixel_q[$];       // items waiting to be offered
   hsb_pixel_type adjusted_q[$];    // predicted results, oldest first

   int  idle_left      = 0;
   bit  back_to_back   = 1'b0;
   int  items_planned  = 0;
   int  items_accepted = 0;
   int  hue_wrapped_in = 0;
   int  results_seen   = 0;
   int  settings_run   = 0;
   int  errors         = 0;
   int  stall_cycles   = 0;

   hue_band_hsb_adjust u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_in_hue         (req_in_hue),
      .req_in_saturation  (req_in_saturation),
      .req_in_brightness  (req_in_brightness),
      .rsp_valid          (rsp_valid),
      .rsp_out_hue        (rsp_out_hue),
      .rsp_out_saturation (rsp_out_saturation),
      .rsp_out_brightness (rsp_out_brightness),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // Packs a hue, saturation and brightness shift into one register value.
   // Each field keeps only its own bits, so out-of-range values wrap.
   function automatic logic [hba_pkg::SHIFT_W-1:0] pack_shift(input int hue_sh,
                                                              input int sat_sh,
                                                              input int bri_sh);
      return {8'(bri_sh), 8'(sat_sh), 9'(hue_sh)};
   endfunction

   // Weighted share of one colour band's shift at the given hue: the whole
   // shift on the flat top, a linear part on the ramps and nothing elsewhere.
   // Division truncates toward zero, as integer division does here.
   function automatic int band_share(input int value, input int band, input int hue);
      int rise_lo;
      int flat_lo;
      int flat_hi;
      int fall_hi;
      rise_lo = BAND_DEG[band][0];
      flat_lo = BAND_DEG[band][1];
      flat_hi = BAND_DEG[band][2];
      fall_hi = BAND_DEG[band][3];
      if (flat_lo < flat_hi) begin
         if (hue < rise_lo || hue > fall_hi) return 0;
         if (hue >= flat_lo && hue <= flat_hi) return value;
      end else begin
         // The wrapping band takes 360 itself as part of its flat top.
         if ((hue >= flat_lo && hue <= HUE_TURN) || hue <= flat_hi) return value;
      end
      if (hue >= rise_lo && hue <= flat_lo)
         return value * (hue - rise_lo) / (flat_lo - rise_lo);
      if (hue >= flat_hi && hue <= fall_hi)
         return value * (fall_hi - hue) / (fall_hi - flat_hi);
      return 0;
   endfunction

   // Predicts the adjusted pixel from the current band shifts.
   function automatic hsb_pixel_type adjust_pixel(input hsb_pixel_type px);
      hsb_pixel_type res;
      int hue;
      int sat;
      int bri;
      int dh;
      int ds;
      int db;
      int hue_sh;
      int sat_sh;
      int bri_sh;
      hue = px.hue;
      sat = px.sat;
      bri = px.bri;
      dh  = 0;
      ds  = 0;
      db  = 0;
      for (int b = 0; b < hba_pkg::NUM_BANDS; b++) begin
         hue_sh = $signed(band_shift[b][8:0]);
         sat_sh = $signed(band_shift[b][16:9]);
         bri_sh = $signed(band_shift[b][24:17]);
         if (b == SHIFT_MASTER) begin
            dh += hue_sh;
            ds += sat_sh;
            db += bri_sh;
         end else begin
            dh += band_share(hue_sh, b - 1, hue);
            ds += band_share(sat_sh, b - 1, hue);
            db += band_share(bri_sh, b - 1, hue);
         end
      end

      // The remainder keeps the sign of the sum, so a negative one is
      // folded back into range.
      hue = (hue + dh) % HUE_TURN;
      if (hue < 0) hue += HUE_TURN;

      // A negative saturation delta scales saturation down; a positive one
      // blends both saturation and brightness toward one.
      ds = (ds > PCT_FULL) ? PCT_FULL : ((ds < -PCT_FULL) ? -PCT_FULL : ds);
      if (ds < 0) begin
         sat = sat * (PCT_FULL + ds) / PCT_FULL;
      end else begin
         sat = sat + (UNITY - sat) * ds / PCT_FULL;
         bri = bri + (UNITY - bri) * ds / PCT_FULL;
      end

      // Brightness comes second and works on the values left by saturation.
      // A positive delta also takes saturation down by the same fraction.
      db = (db > PCT_FULL) ? PCT_FULL : ((db < -PCT_FULL) ? -PCT_FULL : db);
      if (db < 0) begin
         bri = bri * (PCT_FULL + db) / PCT_FULL;
      end else begin
         bri = bri + (UNITY - bri) * db / PCT_FULL;
         sat = sat - sat * db / PCT_FULL;
      end

      res.hue = 9'(hue);
      res.sat = 16'(sat);
      res.bri = 16'(bri);
      return res;
   endfunction

   // Idle time before the next item: mostly none or a few cycles, now and
   // then a long pause.
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic logic [hba_pkg::PIX_W-1:0] random_level();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return 16'($urandom);
   endfunction

   task automatic offer(input int hue, input int sat, input int bri);
      hsb_pixel_type px;
      px.hue = 9'(hue);
      px.sat = 16'(sat);
      px.bri = 16'(bri);
      pixel_q.push_back(px);
      items_planned++;
   endtask

   // Most hues lie in the nominal circle; about one in twelve is above 359,
   // where only the master band and, at 360, the red band apply.
   task automatic offer_random();
      int hue;
      if ($urandom_range(11) == 0) hue = $urandom_range(511, 360);
      else hue = $urandom_range(359);
      offer(hue, random_level(), random_level());
   endtask

   task automatic plan_shifts(input setting_type kind);
      int lone;
      lone = $urandom_range(hba_pkg::NUM_BANDS - 1, 1);
      for (int i = 0; i < hba_pkg::NUM_BANDS; i++) begin
         case (kind)
            SET_ZERO:     shift_plan[i] = '0;
            SET_MAX:      shift_plan[i] = pack_shift(255, 127, 127);
            SET_MIN:      shift_plan[i] = pack_shift(-256, -128, -128);
            SET_ALL_ONES: shift_plan[i] = '1;
            SET_MEANT: begin
               shift_plan[i] = pack_shift(int'($urandom_range(360)) - 180,
                                          int'($urandom_range(200)) - 100,
                                          int'($urandom_range(200)) - 100);
            end
            SET_RAW:         shift_plan[i] = 25'($urandom);
            SET_MASTER_ONLY: shift_plan[i] = (i == SHIFT_MASTER) ? 25'($urandom) : '0;
            default:         shift_plan[i] = (i == lone) ? 25'($urandom) : '0;
         endcase
      end
   endtask

   // Writes every band register from the plan, then the spare index with
   // random data, keeping valid high across back-to-back writes.
   task automatic load_shifts();
      for (int i = 0; i <= SHIFT_NONE; i++) begin
         csr_valid <= 1'b1;
         csr_index <= shift_reg_type'(i);
         csr_wdata <= (i < hba_pkg::NUM_BANDS) ? shift_plan[i] : 25'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // Every item yields exactly one result, so the block is idle once the
   // result count has caught up with the items handed to the driver.
   task automatic wait_drained();
      while (results_seen < items_planned) @(posedge clock);
   endtask

   task automatic flag(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   // Shadow of the band registers, updated at every accepted write.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hba_pkg::NUM_BANDS; i++) band_shift[i] <= '0;
      end else if (csr_valid && csr_ready && csr_index < hba_pkg::NUM_BANDS) begin
         band_shift[csr_index] <= csr_wdata;
      end
   end

   // Driver: an item counts as accepted at an edge with start high and busy
   // low; its prediction is taken right there, from the shifts in force.
   // The next item goes out in the same step unless an idle gap is due.
   always @(posedge clock) begin
      hsb_pixel_type offered;
      hsb_pixel_type next_px;
      logic          drive_next;
      if (reset) begin
         start <= 1'b0;
      end else begin
         drive_next = 1'b0;
         if (start && !busy) begin
            offered.hue = req_in_hue;
            offered.sat = req_in_saturation;
            offered.bri = req_in_brightness;
            adjusted_q.push_back(adjust_pixel(offered));
            items_accepted++;
            if (req_in_hue >= HUE_TURN) hue_wrapped_in++;
            idle_left = back_to_back ? 0 : idle_gap();
         end
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pixel_q.size() > 0) begin
               next_px           = pixel_q.pop_front();
               req_in_hue        <= next_px.hue;
               req_in_saturation <= next_px.sat;
               req_in_brightness <= next_px.bri;
               drive_next        = 1'b1;
            end
            start <= drive_next;
         end
      end
   end

   // Monitor: each strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      hsb_pixel_type seen;
      hsb_pixel_type want;
      if (!reset && rsp_valid) begin
         seen.hue = rsp_out_hue;
         seen.sat = rsp_out_saturation;
         seen.bri = rsp_out_brightness;
         results_seen++;
         if (adjusted_q.size() == 0) begin
            flag($sformatf("result with no item pending: hue %0d sat %0d bri %0d",
                           seen.hue, seen.sat, seen.bri));
         end else begin
            want = adjusted_q.pop_front();
            if (seen.hue !== want.hue || seen.sat !== want.sat || seen.bri !== want.bri)
               flag($sformatf({"result %0d: expected hue %0d sat %0d bri %0d, ",
                               "got hue %0d sat %0d bri %0d"},
                              results_seen, want.hue, want.sat, want.bri,
                              seen.hue, seen.sat, seen.bri));
         end
      end
   end

   // Watchdog: a run of cycles with no item, no result and no register
   // write means the block has hung or lost results.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d results outstanding",
                  stall_cycles, adjusted_q.size());
         $display("hue_band_hsb_adjust regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // With the registers at their reset value the block must pass hue,
      // saturation and brightness straight through, wrapping hues above 359.
      offer(0, 65535, 0);
      offer(359, 0, 65535);
      offer(511, 12345, 54321);
      wait_drained();

      // Directed setting: each band carries its own mix of signs so that
      // both branches of the saturation and brightness rules and both
      // clips come up. Green and cyan hold values outside the meant range,
      // blue holds the most negative hue shift and magenta the largest.
      shift_plan[SHIFT_MASTER]  = pack_shift(-20, -10, 5);
      shift_plan[SHIFT_RED]     = pack_shift(100, -60, 40);
      shift_plan[SHIFT_YELLOW]  = pack_shift(30, 70, -90);
      shift_plan[SHIFT_GREEN]   = pack_shift(-180, 127, 127);
      shift_plan[SHIFT_CYAN]    = pack_shift(180, -128, -128);
      shift_plan[SHIFT_BLUE]    = pack_shift(-256, 30, 30);
      shift_plan[SHIFT_MAGENTA] = pack_shift(255, -100, 100);
      load_shifts();

      // Flat tops, ramps, flat-top edges, the red wrap through zero and
      // hues above the nominal circle, with saturation and brightness at
      // their extremes along the way.
      offer(0, 0, 0);
      offer(15, 65535, 65535);
      offer(30, 32768, 100);
      offer(45, 1, 65534);
      offer(60, 40000, 20000);
      offer(90, 65535, 0);
      offer(105, 0, 65535);
      offer(120, 30000, 30000);
      offer(150, 50000, 10);
      offer(180, 65535, 65535);
      offer(210, 7, 60000);
      offer(240, 20000, 0);
      offer(285, 65535, 12000);
      offer(300, 45000, 45000);
      offer(330, 0, 33333);
      offer(345, 65535, 1);
      offer(359, 22222, 65535);
      offer(360, 32767, 32768);
      offer(361, 65535, 65535);
      offer(511, 0, 0);
      wait_drained();

      // Random phases. The first eight walk through every kind of setting,
      // the rest draw among the random kinds; every third phase offers its
      // items without any idle cycles.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p <= SET_ONE_BAND) plan_shifts(setting_type'(p));
         else plan_shifts(setting_type'($urandom_range(SET_ONE_BAND, SET_MEANT)));
         load_shifts();
         back_to_back = (p % 3 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) offer_random();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (adjusted_q.size() != 0)
         flag($sformatf("%0d predicted results never arrived", adjusted_q.size()));

      $display("Covered %0d pixel items under %0d shift settings, %0d with hue above 359.",
               items_accepted, settings_run + 1, hue_wrapped_in);
      $display("Checked %0d results, %0d failures.", results_seen, errors);
      if (errors == 0) begin
         $display("hue_band_hsb_adjust regression: pass");
      end else begin
         $display("hue_band_hsb_adjust regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/hba_pkg.sv
rtl/core/hba_csr.sv
rtl/core/hba_band_sum.sv
rtl/core/hba_hue_wrap.sv
rtl/core/hba_tone.sv
rtl/core/hue_band_hsb_adjust.sv
bench/testbench.sv
